// ===== sv/gfli_pkg.sv =====
// ----------------------------------------------------------------------------
// gfli_pkg
// Shared types and constants of the gap-fill linear interpolator: command
// format between front and back, result format, sequencer states.
// ----------------------------------------------------------------------------
package gfli_pkg;

  localparam int DataW     = 32;
  localparam int PendW     = 6;
  localparam int GapW      = PendW + 1;
  localparam int AccW      = DataW + 2;
  localparam int DivW      = 40;
  localparam int DivStep   = 8;
  localparam int FifoDepth = 2;

  typedef enum logic [1:0] {
    CMD_PRESENT,
    CMD_TAIL,
    CMD_OVERFLOW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [DataW-1:0]   a;
    logic signed [DataW-1:0]   b;
    logic        [PendW-1:0]   run;
    logic                      seen;
    logic                      rec_end;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    synthesized;
    logic                    gap_overflow;
    logic                    no_data;
    logic                    run_last;
    logic                    record_last;
  } result_t;

endpackage

// ===== sv/gfli_front.sv =====
// ----------------------------------------------------------------------------
// gfli_front
// Accepts input items, tracks the record state and turns every item that
// releases results into one command for the back end.
// ----------------------------------------------------------------------------
module gfli_front #(
  parameter int MaxGap = 63
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          sample_i,
  input  logic                        present_i,
  input  logic                        record_end_i,
  input  logic                        full_i,
  output logic                        push_o,
  output gfli_pkg::cmd_t              cmd_o
);
  import gfli_pkg::*;

  logic signed [DataW-1:0] last_q, last_d;
  logic                    seen_q, seen_d;
  logic [PendW-1:0]        pend_q, pend_d;
  logic                    accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    last_d       = last_q;
    seen_d       = seen_q;
    pend_d       = pend_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_PRESENT;
    cmd_o.a      = last_q;
    cmd_o.b      = sample_i;
    cmd_o.run    = pend_q;
    cmd_o.seen   = seen_q;
    cmd_o.rec_end = record_end_i;
    if (accept) begin
      priority if (present_i) begin
        push_o = 1'b1;
        last_d = sample_i;
        seen_d = 1'b1;
        pend_d = '0;
      end else if (record_end_i) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_TAIL;
        pend_d     = '0;
      end else if (pend_q >= PendW'(MaxGap)) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_OVERFLOW;
        pend_d     = '0;
      end else begin
        pend_d = pend_q + PendW'(1);
      end
      if (record_end_i) begin
        last_d = '0;
        seen_d = 1'b0;
        pend_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      seen_q <= 1'b0;
      pend_q <= '0;
    end else begin
      last_q <= last_d;
      seen_q <= seen_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== sv/gfli_fifo.sv =====
// ----------------------------------------------------------------------------
// gfli_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module gfli_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gfli_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output gfli_pkg::cmd_t head_o
);
  import gfli_pkg::*;

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/gfli_div.sv =====
// ----------------------------------------------------------------------------
// gfli_div
// Unsigned restoring divider by a small gap length, several quotient bits
// per cycle; done pulses one cycle with quotient and remainder valid.
// ----------------------------------------------------------------------------
module gfli_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gfli_pkg::DivW-1:0]     dividend_i,
  input  logic [gfli_pkg::GapW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [gfli_pkg::DivW-1:0]     quot_o,
  output logic [gfli_pkg::GapW-1:0]     rem_o
);
  import gfli_pkg::*;

  localparam int Steps = DivW / DivStep;
  localparam int CntW  = (Steps > 1) ? $clog2(Steps) : 1;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] num_q, num_d;
  logic [GapW-1:0] rem_q, rem_d, den_q;

  always_comb begin
    logic [GapW:0] t;
    num_d = num_q;
    rem_d = rem_q;
    for (int i = 0; i < DivStep; i++) begin
      t     = {rem_d, num_d[DivW-1]};
      num_d = {num_d[DivW-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        rem_d    = GapW'(t - {1'b0, den_q});
        num_d[0] = 1'b1;
      end else begin
        rem_d = t[GapW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/gfli_back.sv =====
// ----------------------------------------------------------------------------
// gfli_back
// Takes commands from the queue and emits their results one per cycle while the output is not stalled.
// An interpolated run needs one division of the step by the gap length;
// the fills then follow from a running quotient and remainder.
// ----------------------------------------------------------------------------
module gfli_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  gfli_pkg::cmd_t        head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gfli_pkg::result_t     res_o
);
  import gfli_pkg::*;

  back_state_e             state_q, state_d;
  cmd_t                    cmd_q;
  logic [PendW-1:0]        idx_q;
  logic signed [AccW-1:0]  q_q, dq_q;
  logic [GapW-1:0]         r_q, dr_q;
  logic                    neg_q;
  logic                    out_valid_q;
  result_t                 res_q, res;

  logic                    need_div, div_start, div_done;
  logic signed [DataW:0]   diff;
  logic [DataW:0]          mag;
  logic [DivW-1:0]         quot;
  logic [GapW-1:0]         rem, g, g_head;
  logic signed [AccW-1:0]  qmag, dq_fix, q_adv, interp;
  logic [GapW-1:0]         dr_fix;
  logic [GapW:0]           rsum;
  logic                    carry, slot_free, emit, last;

  assign g_head   = {1'b0, head_i.run} + GapW'(1);
  assign g        = {1'b0, cmd_q.run} + GapW'(1);
  assign need_div = (head_i.kind == CMD_PRESENT) && head_i.seen && (head_i.run != '0);
  assign diff     = {head_i.b[DataW-1], head_i.b} - {head_i.a[DataW-1], head_i.a};
  assign mag      = diff[DataW] ? (~diff + 1'b1) : diff;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign div_start = pop_o && need_div;

  gfli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DivW'(mag)),
    .divisor_i  (g_head),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // floor division of the signed step
  always_comb begin
    qmag = quot[AccW-1:0];
    if (neg_q) begin
      if (rem != '0) begin
        dq_fix = -qmag - AccW'(1);
        dr_fix = g - rem;
      end else begin
        dq_fix = -qmag;
        dr_fix = '0;
      end
    end else begin
      dq_fix = qmag;
      dr_fix = rem;
    end
  end

  assign rsum   = {1'b0, r_q} + {1'b0, dr_q};
  assign carry  = (rsum >= {1'b0, g});
  assign q_adv  = q_q + dq_q + (carry ? AccW'(1) : AccW'(0));
  // floor to truncation toward zero
  assign interp = q_q + ((q_q[AccW-1] && (r_q != '0)) ? AccW'(1) : AccW'(0));

  assign slot_free = !out_valid_q || !out_stall_i;
  assign last      = (idx_q == cmd_q.run);
  assign emit      = (state_q == B_EMIT) && slot_free;

  always_comb begin
    res.value        = cmd_q.a;
    res.synthesized  = 1'b1;
    res.gap_overflow = 1'b0;
    res.no_data      = 1'b0;
    res.run_last     = last;
    res.record_last  = last && cmd_q.rec_end;
    unique case (cmd_q.kind)
      CMD_PRESENT: begin
        if (last) begin
          res.value       = cmd_q.b;
          res.synthesized = 1'b0;
        end else if (cmd_q.seen) begin
          res.value = interp[DataW-1:0];
        end else begin
          res.value = cmd_q.b;
        end
      end
      CMD_TAIL: begin
        res.no_data = !cmd_q.seen;
      end
      CMD_OVERFLOW: begin
        res.gap_overflow = 1'b1;
      end
      default: begin
        res.synthesized = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = need_div ? B_DIV : B_EMIT;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (emit && last) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
      idx_q <= '0;
      neg_q <= diff[DataW];
    end else if (state_q == B_DIV && div_done) begin
      q_q  <= {{(AccW-DataW){cmd_q.a[DataW-1]}}, cmd_q.a} + dq_fix;
      r_q  <= dr_fix;
      dq_q <= dq_fix;
      dr_q <= dr_fix;
    end else if (emit && !last) begin
      idx_q <= idx_q + PendW'(1);
      q_q   <= q_adv;
      r_q   <= carry ? GapW'(rsum - {1'b0, g}) : rsum[GapW-1:0];
    end
    if (emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/gap_fill_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// gap_fill_linear_interpolator
// Fills missing samples of a record by Q16.16 linear interpolation.
// ----------------------------------------------------------------------------
// A missing item is held as a count and gives no result until a present
// item, the record end or a gap longer than MAX_GAP releases the run. An item
// that releases n results occupies the back end until all n are emitted; a run
// that is interpolated first waits for one division of the step by the gap
// length (in steps of eight quotient bits each), after which fills come one
// per cycle from a running quotient and remainder while the output is not
// stalled. Held missing items and items of a plain record are taken one per
// cycle while the two-entry command queue has room.
module gap_fill_linear_interpolator #(
  parameter int MAX_GAP = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] sample_i,
  input  logic               present_i,
  input  logic               record_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               synthesized_o,
  output logic               gap_overflow_o,
  output logic               no_data_o,
  output logic               run_last_o,
  output logic               record_last_o
);
  import gfli_pkg::*;

  cmd_t    push_cmd, head;
  logic    push, full, pop, empty;
  result_t res;

  gfli_front #(
    .MaxGap (MAX_GAP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .present_i    (present_i),
    .record_end_i (record_end_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  gfli_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  gfli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign value_o        = res.value;
  assign synthesized_o  = res.synthesized;
  assign gap_overflow_o = res.gap_overflow;
  assign no_data_o      = res.no_data;
  assign run_last_o     = res.run_last;
  assign record_last_o  = res.record_last;

endmodule
